[src/bounded_deque_engine_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque engine
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_ASSERT_SVH
`define BOUNDED_DEQUE_ENGINE_ASSERT_SVH

// Same-cycle implication
`define BDE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BDE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bde_pkg.sv]
// ----------------------------------------------------------------------------
// bde_pkg
// Types, codes and sizes shared by the bounded deque engine files.
// ----------------------------------------------------------------------------
package bde_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		ACT_PUSH_FRONT = 4'd0,
		ACT_PUSH_BACK  = 4'd1,
		ACT_POP_FRONT  = 4'd2,
		ACT_POP_BACK   = 4'd3,
		ACT_CLEAR      = 4'd4,
		ACT_REMOVE     = 4'd5,
		ACT_DUMP_ALL   = 4'd6,
		ACT_DUMP_FIRST = 4'd7,
		ACT_DUMP_LAST  = 4'd8
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EMIT,
		S_SEARCH,
		S_SHIFT,
		S_DSETUP,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [31:0] item_value;
		logic [7:0]         dump_count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic               has_value;
		logic               last_of_run;
		logic [1:0]         status;
	} rsp_t;

endpackage

[src/bde_ram.sv]
// ----------------------------------------------------------------------------
// bde_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module bde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, hold data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/bounded_deque_engine.sv]
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed values with search-remove and dumps.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req (valid/ready); results leave on rsp (valid/ready).
//   req_ready is high only while the sequencer is idle; one request is worked
//   at a time. Entries sit in a circular RAM with a registered read port.
//   Push, pop, clear and unused codes: one status beat per request.
//   Remove by value: walks the entries one per cycle through the RAM read
//   port, then shifts the tail down one entry per cycle.
//   Dumps: a set-up state fetches the first entry, then one beat per entry
//   each cycle the output register is free, the final beat flagged last_of_run.
//   An empty dump gives one beat with has_value low.
//   A result beat waits in an output register; while it waits with rsp_ready
//   low, emit and dump states hold, RAM read data holds, no result is lost.
//   Reset clears the count, the front position and the sequencer; the RAM
//   contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
`include "bounded_deque_engine_assert.svh"

module bounded_deque_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bde_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bde_pkg::rsp_t rsp
);

	localparam int IDX_W = bde_pkg::IDX_W;
	localparam int CNT_W = bde_pkg::CNT_W;
	localparam int SUM_W = CNT_W + 1;
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	bde_pkg::state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0] end_q, end_d;
	logic [31:0]      value_q, value_d;
	logic [1:0]       emit_status_q, emit_status_d;
	logic             out_valid_q;
	bde_pkg::rsp_t    out_q, out_d;
	logic             out_load;
	logic             out_free;
	logic             accept;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;

	logic [CMP_W-1:0] dc_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [CNT_W-1:0] dump_n;

	// Map a front-relative offset onto a RAM slot
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(bde_pkg::CAPACITY)) begin
			sum = sum - SUM_W'(bde_pkg::CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	bde_ram #(
		.WIDTH(bde_pkg::VALUE_W),
		.DEPTH(bde_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == bde_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Clip the dump length to the stored count
	assign dc_ext  = CMP_W'(req.dump_count);
	assign cnt_ext = CMP_W'(count_q);
	assign dump_n  = (dc_ext > cnt_ext) ? count_q : dc_ext[CNT_W-1:0];

	// Sequencer: next state, RAM controls and result beats
	always_comb begin
		state_d       = state_q;
		front_d       = front_q;
		count_d       = count_q;
		ptr_d         = ptr_q;
		end_d         = end_q;
		value_d       = value_q;
		emit_status_d = emit_status_q;
		out_load      = 1'b0;
		out_d         = '0;
		ram_we        = 1'b0;
		ram_waddr     = front_q;
		ram_wdata     = req.item_value;
		ram_re        = 1'b0;
		ram_raddr     = front_q;

		unique case (state_q)
			bde_pkg::S_IDLE: begin
				if (accept) begin
					state_d       = bde_pkg::S_EMIT;
					emit_status_d = bde_pkg::STAT_OK;
					unique case (req.action)
						bde_pkg::ACT_PUSH_FRONT: begin
							if (count_q == CNT_W'(bde_pkg::CAPACITY)) begin
								emit_status_d = bde_pkg::STAT_FULL;
							end else begin
								front_d   = (front_q == '0) ?
									IDX_W'(bde_pkg::CAPACITY - 1) : front_q - IDX_W'(1);
								ram_we    = 1'b1;
								ram_waddr = front_d;
								count_d   = count_q + CNT_W'(1);
							end
						end
						bde_pkg::ACT_PUSH_BACK: begin
							if (count_q == CNT_W'(bde_pkg::CAPACITY)) begin
								emit_status_d = bde_pkg::STAT_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = slot_of(front_q, count_q);
								count_d   = count_q + CNT_W'(1);
							end
						end
						bde_pkg::ACT_POP_FRONT: begin
							if (count_q == '0) begin
								emit_status_d = bde_pkg::STAT_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
								front_d = (count_d == '0) ? '0 : slot_of(front_q, CNT_W'(1));
							end
						end
						bde_pkg::ACT_POP_BACK: begin
							if (count_q == '0) begin
								emit_status_d = bde_pkg::STAT_EMPTY;
							end else begin
								count_d = count_q - CNT_W'(1);
								if (count_d == '0) begin
									front_d = '0;
								end
							end
						end
						bde_pkg::ACT_CLEAR: begin
							count_d = '0;
							front_d = '0;
						end
						bde_pkg::ACT_REMOVE: begin
							if (count_q == '0) begin
								emit_status_d = bde_pkg::STAT_EMPTY;
							end else begin
								// Start the walk at the front entry
								value_d   = req.item_value;
								ptr_d     = '0;
								ram_re    = 1'b1;
								ram_raddr = front_q;
								state_d   = bde_pkg::S_SEARCH;
							end
						end
						bde_pkg::ACT_DUMP_ALL: begin
							if (count_q != '0) begin
								ptr_d   = '0;
								end_d   = count_q;
								state_d = bde_pkg::S_DSETUP;
							end
						end
						bde_pkg::ACT_DUMP_FIRST: begin
							if (dump_n != '0) begin
								ptr_d   = '0;
								end_d   = dump_n;
								state_d = bde_pkg::S_DSETUP;
							end
						end
						bde_pkg::ACT_DUMP_LAST: begin
							if (dump_n != '0) begin
								ptr_d   = count_q - dump_n;
								end_d   = count_q;
								state_d = bde_pkg::S_DSETUP;
							end
						end
						default: begin
							emit_status_d = bde_pkg::STAT_OK;
						end
					endcase
				end
			end

			bde_pkg::S_EMIT: begin
				// Hand one status beat to the output register
				if (out_free) begin
					out_load          = 1'b1;
					out_d.out_value   = '0;
					out_d.has_value   = 1'b0;
					out_d.last_of_run = 1'b1;
					out_d.status      = emit_status_q;
					state_d           = bde_pkg::S_IDLE;
				end
			end

			bde_pkg::S_SEARCH: begin
				// Compare the entry at ptr, prefetch the next one
				if (ram_rdata == value_q) begin
					if (ptr_q + CNT_W'(1) == count_q) begin
						count_d       = count_q - CNT_W'(1);
						if (count_d == '0) begin
							front_d = '0;
						end
						emit_status_d = bde_pkg::STAT_OK;
						state_d       = bde_pkg::S_EMIT;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = slot_of(front_q, ptr_q + CNT_W'(1));
						state_d   = bde_pkg::S_SHIFT;
					end
				end else if (ptr_q + CNT_W'(1) == count_q) begin
					emit_status_d = bde_pkg::STAT_NOT_FOUND;
					state_d       = bde_pkg::S_EMIT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = slot_of(front_q, ptr_q + CNT_W'(1));
					ptr_d     = ptr_q + CNT_W'(1);
				end
			end

			bde_pkg::S_SHIFT: begin
				// Move entry ptr+1 down into ptr, prefetch ptr+2
				ram_we    = 1'b1;
				ram_waddr = slot_of(front_q, ptr_q);
				ram_wdata = ram_rdata;
				if (ptr_q + CNT_W'(2) == count_q) begin
					count_d       = count_q - CNT_W'(1);
					emit_status_d = bde_pkg::STAT_OK;
					state_d       = bde_pkg::S_EMIT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = slot_of(front_q, ptr_q + CNT_W'(2));
					ptr_d     = ptr_q + CNT_W'(1);
				end
			end

			bde_pkg::S_DSETUP: begin
				// Fetch the first dumped entry
				ram_re    = 1'b1;
				ram_raddr = slot_of(front_q, ptr_q);
				state_d   = bde_pkg::S_DUMP;
			end

			bde_pkg::S_DUMP: begin
				// Send one entry per free output slot, prefetch the next
				if (out_free) begin
					out_load          = 1'b1;
					out_d.out_value   = ram_rdata;
					out_d.has_value   = 1'b1;
					out_d.last_of_run = (ptr_q + CNT_W'(1) == end_q);
					out_d.status      = bde_pkg::STAT_OK;
					if (ptr_q + CNT_W'(1) == end_q) begin
						state_d = bde_pkg::S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = slot_of(front_q, ptr_q + CNT_W'(1));
						ptr_d     = ptr_q + CNT_W'(1);
					end
				end
			end

			default: begin
				state_d = bde_pkg::S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bde_pkg::S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			end_q   <= end_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		value_q       <= value_d;
		emit_status_q <= emit_status_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	`BDE_ASSERT_IMP(a_out_no_overwrite, out_load, !out_valid_q || rsp_ready,
		"result beat loaded over an untaken one")
	`BDE_ASSERT_IMP(a_empty_front_zero, count_q == '0, front_q == '0,
		"empty queue with nonzero front position")
	`BDE_ASSERT_IMP(a_ram_no_collide, ram_we && ram_re, ram_waddr != ram_raddr,
		"shift writes the slot it prefetches")
	`BDE_ASSERT_NXT(a_dump_range, state_q == bde_pkg::S_DSETUP,
		state_q == bde_pkg::S_DUMP && ptr_q < end_q && end_q <= count_q,
		"dump walk outside stored entries")

endmodule

[tb/tb_bounded_deque_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_deque_engine
// Self-checking bench for the bounded deque engine. Requests go in through a
// valid/ready sender, and a mirror deque in the bench predicts every result
// beat. A checker compares each accepted beat with the oldest prediction.
// The run covers directed corner cases, a long receiver hold-off against a
// full deque, and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_bounded_deque_engine;

	// action codes past the last defined one; the engine answers them with a plain ok
	localparam logic [3:0] ACT_UNUSED_FIRST = 4'd9;
	localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;
	localparam int         HOLD_CYCLES      = 300;
	localparam int         TAIL_CYCLES      = 40;
	localparam int         MAX_SEND_GAP     = 20;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	bde_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	bde_pkg::rsp_t rsp;

	// mirror of the deque contents
	logic signed [31:0] mirror_store [bde_pkg::CAPACITY];
	int                 mirror_front = 0;
	int                 mirror_count = 0;
	bde_pkg::rsp_t      expected_rsps [$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int rsp_stall_pct  = 0;
	int hold_reqs      = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	bounded_deque_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int slot_of(input int offset);
		return (mirror_front + offset) % bde_pkg::CAPACITY;
	endfunction

	function automatic bde_pkg::req_t make_req(input logic [3:0] act, input int value,
		input int count);
		bde_pkg::req_t r;
		r.action     = act;
		r.item_value = value;
		r.dump_count = 8'(count);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Apply one request to the mirror deque and queue the beats it should produce
	task automatic predict_deque(input bde_pkg::req_t r);
		bde_pkg::rsp_t beat;
		int            run_len;
		int            run_first;
		int            hit;
		beat             = '0;
		beat.last_of_run = 1'b1;
		beat.status      = bde_pkg::STAT_OK;
		run_len          = 0;
		run_first        = 0;
		hit              = -1;
		case (r.action)
			bde_pkg::ACT_PUSH_FRONT: begin
				if (mirror_count >= bde_pkg::CAPACITY) begin
					beat.status = bde_pkg::STAT_FULL;
				end else begin
					mirror_front = (mirror_front + bde_pkg::CAPACITY - 1) % bde_pkg::CAPACITY;
					mirror_store[mirror_front] = r.item_value;
					mirror_count++;
				end
			end
			bde_pkg::ACT_PUSH_BACK: begin
				if (mirror_count >= bde_pkg::CAPACITY) begin
					beat.status = bde_pkg::STAT_FULL;
				end else begin
					mirror_store[slot_of(mirror_count)] = r.item_value;
					mirror_count++;
				end
			end
			bde_pkg::ACT_POP_FRONT: begin
				if (mirror_count == 0) begin
					beat.status = bde_pkg::STAT_EMPTY;
				end else begin
					mirror_front = slot_of(1);
					mirror_count--;
					if (mirror_count == 0) mirror_front = 0;
				end
			end
			bde_pkg::ACT_POP_BACK: begin
				if (mirror_count == 0) begin
					beat.status = bde_pkg::STAT_EMPTY;
				end else begin
					mirror_count--;
					if (mirror_count == 0) mirror_front = 0;
				end
			end
			bde_pkg::ACT_CLEAR: begin
				mirror_count = 0;
				mirror_front = 0;
			end
			bde_pkg::ACT_REMOVE: begin
				if (mirror_count == 0) begin
					beat.status = bde_pkg::STAT_EMPTY;
				end else begin
					for (int i = 0; i < mirror_count; i++)
						if (hit < 0 && mirror_store[slot_of(i)] == r.item_value) hit = i;
					if (hit < 0) begin
						beat.status = bde_pkg::STAT_NOT_FOUND;
					end else begin
						// close the gap, keeping the order of the rest
						for (int j = hit; j + 1 < mirror_count; j++)
							mirror_store[slot_of(j)] = mirror_store[slot_of(j + 1)];
						mirror_count--;
						if (mirror_count == 0) mirror_front = 0;
					end
				end
			end
			bde_pkg::ACT_DUMP_ALL: begin
				run_len = mirror_count;
			end
			bde_pkg::ACT_DUMP_FIRST: begin
				run_len = (int'(r.dump_count) > mirror_count) ?
					mirror_count : int'(r.dump_count);
			end
			bde_pkg::ACT_DUMP_LAST: begin
				run_len   = (int'(r.dump_count) > mirror_count) ?
					mirror_count : int'(r.dump_count);
				run_first = mirror_count - run_len;
			end
			default: begin
			end
		endcase
		if (run_len > 0) begin
			for (int k = 0; k < run_len; k++) begin
				beat.out_value   = mirror_store[slot_of(run_first + k)];
				beat.has_value   = 1'b1;
				beat.last_of_run = (k == run_len - 1);
				expected_rsps.push_back(beat);
			end
		end else begin
			expected_rsps.push_back(beat);
		end
	endtask

	// Offer one request beat, with a random idle gap first, and predict once accepted
	task automatic send_req(input bde_pkg::req_t r);
		int gap;
		gap = 0;
		while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		predict_deque(r);
	endtask

	// Hold the sender until every predicted beat has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_rsps.size() != 0);
		@(posedge clk);
	endtask

	// Drive rsp_ready: long counted hold-off on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// Check each accepted result beat against the oldest prediction
	always @(posedge clk) begin : check_beat
		bde_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch($sformatf("unexpected beat value %0d status %0d",
					rsp.out_value, rsp.status));
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.out_value !== want.out_value)
					report_mismatch($sformatf("out_value got %0d want %0d",
						rsp.out_value, want.out_value));
				if (rsp.has_value !== want.has_value)
					report_mismatch($sformatf("has_value got %b want %b",
						rsp.has_value, want.has_value));
				if (rsp.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run got %b want %b",
						rsp.last_of_run, want.last_of_run));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, want.status));
			end
		end
	end

	// Corner cases: empty deque, value extremes, dump limits, unused code, clear
	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct <= 0;
		send_req(make_req(bde_pkg::ACT_POP_FRONT, 0, 0));
		send_req(make_req(bde_pkg::ACT_POP_BACK, 0, 0));
		send_req(make_req(bde_pkg::ACT_REMOVE, 7, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_ALL, 0, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_FIRST, 0, 5));
		send_req(make_req(bde_pkg::ACT_DUMP_LAST, 0, 255));
		send_req(make_req(bde_pkg::ACT_PUSH_FRONT, int'(32'h7FFF_FFFF), 0));
		send_req(make_req(bde_pkg::ACT_PUSH_BACK, int'(32'h8000_0000), 0));
		send_req(make_req(bde_pkg::ACT_PUSH_BACK, -1, 0));
		send_req(make_req(bde_pkg::ACT_PUSH_FRONT, 0, 0));
		send_req(make_req(bde_pkg::ACT_PUSH_BACK, -1, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_ALL, 0, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_FIRST, 0, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_FIRST, 0, 255));
		send_req(make_req(bde_pkg::ACT_DUMP_LAST, 0, 2));
		send_req(make_req(bde_pkg::ACT_REMOVE, 12345, 0));
		// duplicate -1: only the first one goes
		send_req(make_req(bde_pkg::ACT_REMOVE, -1, 0));
		send_req(make_req(bde_pkg::ACT_REMOVE, int'(32'h8000_0000), 0));
		send_req(make_req(bde_pkg::ACT_DUMP_ALL, 0, 0));
		send_req(make_req(bde_pkg::ACT_POP_FRONT, 0, 0));
		send_req(make_req(bde_pkg::ACT_POP_BACK, 0, 0));
		send_req(make_req(ACT_UNUSED_LAST, 0, 0));
		send_req(make_req(bde_pkg::ACT_CLEAR, 0, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_ALL, 0, 0));
		wait_drained();
	endtask

	// Fill past capacity while the receiver holds off, so the engine stalls its input
	task automatic test_full_under_hold();
		send_idle_pct = 0;
		rsp_stall_pct <= 0;
		send_req(make_req(bde_pkg::ACT_CLEAR, 0, 0));
		hold_reqs <= hold_reqs + 1;
		for (int i = 0; i < bde_pkg::CAPACITY + 2; i++)
			send_req(make_req($urandom_range(1) ?
				bde_pkg::ACT_PUSH_BACK : bde_pkg::ACT_PUSH_FRONT, $urandom, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_ALL, 0, 0));
		send_req(make_req(bde_pkg::ACT_REMOVE,
			mirror_store[slot_of(bde_pkg::CAPACITY / 2)], 0));
		send_req(make_req(bde_pkg::ACT_DUMP_LAST, 0, 3));
		send_req(make_req(bde_pkg::ACT_POP_FRONT, 0, 0));
		send_req(make_req(bde_pkg::ACT_POP_BACK, 0, 0));
		send_req(make_req(bde_pkg::ACT_DUMP_FIRST, 0, bde_pkg::CAPACITY));
		wait_drained();
	endtask

	// Random traffic; push weight swings so the deque moves between empty and full
	task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct);
		logic [3:0] act;
		int         push_w;
		int         pick;
		int         value;
		int         count;
		send_idle_pct = send_pct;
		rsp_stall_pct <= recv_pct;
		push_w = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 16 == 0) push_w = 25 + 25 * $urandom_range(2);
			pick = $urandom_range(99);
			if ($urandom_range(99) < push_w)
				act = $urandom_range(1) ? bde_pkg::ACT_PUSH_BACK : bde_pkg::ACT_PUSH_FRONT;
			else if (pick < 30)
				act = $urandom_range(1) ? bde_pkg::ACT_POP_BACK : bde_pkg::ACT_POP_FRONT;
			else if (pick < 55)
				act = bde_pkg::ACT_REMOVE;
			else if (pick < 67)
				act = bde_pkg::ACT_DUMP_ALL;
			else if (pick < 79)
				act = bde_pkg::ACT_DUMP_FIRST;
			else if (pick < 90)
				act = bde_pkg::ACT_DUMP_LAST;
			else if (pick < 94)
				act = bde_pkg::ACT_CLEAR;
			else
				act = 4'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
			// small values give duplicates for remove-first-match
			if (act == bde_pkg::ACT_REMOVE && mirror_count > 0 && $urandom_range(99) < 70)
				value = mirror_store[slot_of($urandom_range(mirror_count - 1))];
			else if ($urandom_range(99) < 40)
				value = int'($urandom_range(6)) - 3;
			else
				value = $urandom;
			count = ($urandom_range(99) < 80) ?
				$urandom_range(bde_pkg::CAPACITY + 2) : $urandom_range(255);
			send_req(make_req(act, value, count));
		end
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_under_hold();
		test_random_phase(53, 0, 0);
		test_random_phase(53, 60, 0);
		test_random_phase(53, 0, 60);
		test_random_phase(53, 15, 15);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Bound the run in case the engine hangs
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
